// ===== rtl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared constants, types and helpers of the Laplacian stencil filter.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int PIX_W      = 8;
  localparam int LAP_W      = 11;
  localparam int FW_W       = 11;
  localparam int FH_W       = 16;
  localparam int DIM_W      = (CNT_W > FW_W) ? CNT_W : FW_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(1024);
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(1);

  typedef struct packed {
    logic              go;
    logic              emit;
    logic              left_z;
    logic              right_z;
    logic              up_z;
    logic              down_z;
    logic              last;
    logic [ADDR_W-1:0] col;
    logic [PIX_W-1:0]  below;
  } step_ctl_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } ram_wr_t;

  function automatic logic [CNT_W-1:0] eff_width(input logic [FW_W-1:0] fw);
    logic [DIM_W-1:0] ext;
    ext = DIM_W'(fw);
    if (fw == '0) return CNT_W'(1);
    if (ext > DIM_W'(MAX_WIDTH)) return CNT_W'(MAX_WIDTH);
    return CNT_W'(fw);
  endfunction

endpackage

// ===== rtl/lsf_line_ram.sv =====
// ----------------------------------------------------------------------------
// lsf_line_ram
// One row of pixel storage with a registered, read-first read port.
// ----------------------------------------------------------------------------
module lsf_line_ram (
  input  logic                      clk,
  input  logic                      re,
  input  logic [lsf_pkg::ADDR_W-1:0] raddr,
  output logic [lsf_pkg::PIX_W-1:0]  rdata,
  input  logic                      we,
  input  logic [lsf_pkg::ADDR_W-1:0] waddr,
  input  logic [lsf_pkg::PIX_W-1:0]  wdata
);
  import lsf_pkg::*;

  logic [PIX_W-1:0] mem [MAX_WIDTH];
  logic [PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/lsf_seq.sv =====
// ----------------------------------------------------------------------------
// lsf_seq
// Configuration registers and raster counters; classifies each item.
// ----------------------------------------------------------------------------
module lsf_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic                          in_op,
  input  logic [lsf_pkg::PIX_W-1:0]      in_pixel,
  input  logic                          cfg_we,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0] cfg_data,
  output lsf_pkg::step_ctl_t            ctl,
  output logic [lsf_pkg::ADDR_W-1:0]     wr_col,
  output logic [lsf_pkg::PIX_W-1:0]      wr_val
);
  import lsf_pkg::*;

  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [ADDR_W-1:0] in_col_r, in_col_nxt;
  logic [FH_W-1:0]   in_row_r, in_row_nxt;
  logic [ADDR_W-1:0] out_col_r, out_col_nxt;
  logic [FH_W-1:0]   out_row_r, out_row_nxt;
  logic [CNT_W-1:0]  lead_r, lead_nxt;
  logic [PIX_W-1:0]  prev_val_r;

  logic [CNT_W-1:0]  w;
  logic [FH_W-1:0]   h;
  logic              drain, inputs_done, go, emit, in_wrap;
  logic              left_z, right_z, up_z, down_z, last;
  logic [CNT_W-1:0]  in_col_inc, out_col_inc;
  logic [PIX_W-1:0]  val;

  always_comb begin
    w           = eff_width(frame_width_r);
    h           = (frame_height_r == '0) ? FH_W'(1) : frame_height_r;
    drain       = (in_op == OP_DRAIN);
    inputs_done = (in_row_r >= h);
    go          = !(drain && !inputs_done);
    val         = (!inputs_done && !drain) ? in_pixel : '0;
    in_col_inc  = CNT_W'(in_col_r) + CNT_W'(1);
    in_wrap     = (in_col_inc >= w);
    emit        = (lead_r > w);
    out_col_inc = CNT_W'(out_col_r) + CNT_W'(1);
    left_z      = (out_col_r == '0);
    right_z     = (out_col_inc >= w);
    up_z        = (out_row_r == '0);
    down_z      = ({1'b0, out_row_r} + (FH_W+1)'(1)) >= {1'b0, h};
    last        = down_z && right_z;

    in_col_nxt  = in_wrap ? '0 : in_col_inc[ADDR_W-1:0];
    in_row_nxt  = (in_wrap && !inputs_done) ? in_row_r + FH_W'(1) : in_row_r;
    lead_nxt    = emit ? lead_r : lead_r + CNT_W'(1);
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (emit) begin
      out_col_nxt = right_z ? '0 : out_col_inc[ADDR_W-1:0];
      out_row_nxt = right_z ? out_row_r + FH_W'(1) : out_row_r;
    end
    if (emit && last) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      lead_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      lead_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lead_r    <= '0;
    end else if (accept && go) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lead_r    <= lead_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && go) begin
      prev_val_r <= val;
    end
  end

  always_comb begin
    ctl.go      = go;
    ctl.emit    = emit;
    ctl.left_z  = left_z;
    ctl.right_z = right_z;
    ctl.up_z    = up_z;
    ctl.down_z  = down_z;
    ctl.last    = last;
    ctl.col     = out_col_r;
    ctl.below   = prev_val_r;
  end

  assign wr_col = in_col_r;
  assign wr_val = val;

endmodule

// ===== rtl/lsf_stencil.sv =====
// ----------------------------------------------------------------------------
// lsf_stencil
// Pixel window, row-above write-back with forwarding, stencil sum and the
// output register.
// ----------------------------------------------------------------------------
module lsf_stencil (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           take,
  input  lsf_pkg::step_ctl_t             ctl,
  input  logic [lsf_pkg::PIX_W-1:0]       centre_rdata,
  input  logic [lsf_pkg::PIX_W-1:0]       above_rdata,
  output lsf_pkg::ram_wr_t               above_wr,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [lsf_pkg::LAP_W-1:0] out_laplacian,
  output logic                           out_last_of_frame
);
  import lsf_pkg::*;

  step_ctl_t          s1_r;
  logic               s1_valid_r;
  logic               fwd_r;
  logic [PIX_W-1:0]   fwd_data_r;
  logic [PIX_W-1:0]   win1_r, win2_r;
  logic               out_valid_r;
  logic signed [LAP_W-1:0] lap_r;
  logic               last_r;

  logic               out_free, s1_adv;
  logic [PIX_W-1:0]   above, up, down, left, right, centre;
  logic [LAP_W-1:0]   sum4;
  logic signed [LAP_W-1:0] lap_nxt;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_adv   = s1_valid_r && out_free;
    in_stall = s1_valid_r && !out_free;

    above  = fwd_r ? fwd_data_r : above_rdata;
    centre = win2_r;
    left   = s1_r.left_z  ? '0 : win1_r;
    right  = s1_r.right_z ? '0 : centre_rdata;
    up     = s1_r.up_z    ? '0 : above;
    down   = s1_r.down_z  ? '0 : s1_r.below;
    sum4   = LAP_W'(up) + LAP_W'(down) + LAP_W'(left) + LAP_W'(right);
    lap_nxt = $signed(sum4 - (LAP_W'(centre) << 2));

    above_wr.en   = s1_adv && s1_r.emit;
    above_wr.addr = s1_r.col;
    above_wr.data = win2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      win1_r      <= '0;
      win2_r      <= '0;
    end else begin
      if (take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        win1_r <= '0;
        win2_r <= '0;
      end else if (s1_adv) begin
        if (s1_r.emit && s1_r.last) begin
          win1_r <= '0;
          win2_r <= '0;
        end else begin
          win1_r <= win2_r;
          win2_r <= centre_rdata;
        end
      end
      if (s1_adv && s1_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_r       <= ctl;
      fwd_r      <= above_wr.en && (above_wr.addr == ctl.col);
      fwd_data_r <= win2_r;
    end
    if (s1_adv && s1_r.emit) begin
      lap_r  <= lap_nxt;
      last_r <= s1_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_laplacian     = lap_r;
  assign out_last_of_frame = last_r;

endmodule

// ===== rtl/laplacian_stencil_filter.sv =====
// ----------------------------------------------------------------------------
// laplacian_stencil_filter
// Streaming 5-point Laplacian of a raster-order grayscale frame.
//
// The input channel carries one item per pixel (op = pixel) and, once the
// frame is in, drain items (op = drain) that push the last row out. The
// result for a frame position is computed in the store stage from the item
// that follows it by one row plus one pixel, and is loaded into the output
// register when that stage advances, so the stream runs W + 1 items ahead
// of the results; W + 1 drain items finish a frame, and the result flagged
// last_of_frame ends it. Early drains produce nothing. Throughput is one item
// per cycle unless the receiver stalls: each item makes one read of each line
// store and at most one write to each, and the stage after the stores reads
// the row above with forwarding from the write-back in flight.
// The configuration port is always ready; a write restarts the stream and is
// to be issued only while no result is outstanding. Reset clears the counters
// and the window and sets a width of 1024 and a height of 1; the line stores
// are not cleared. When the receiver stalls, the result is held in the output
// register; an item is still taken into the store stage only while that stage
// is empty, and the input channel stalls as soon as it holds one.
// ----------------------------------------------------------------------------
module laplacian_stencil_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [lsf_pkg::PIX_W-1:0]       in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [lsf_pkg::LAP_W-1:0] out_laplacian,
  output logic                           out_last_of_frame,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsf_pkg::*;

  step_ctl_t         ctl;
  ram_wr_t           above_wr;
  logic              accept, take, cfg_we;
  logic [ADDR_W-1:0] wr_col;
  logic [PIX_W-1:0]  wr_val;
  logic [PIX_W-1:0]  centre_rdata, above_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;
  assign take      = accept && ctl.go;

  lsf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_op     (in_op),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .wr_col    (wr_col),
    .wr_val    (wr_val)
  );

  lsf_line_ram u_centre_ram (
    .clk   (clk),
    .re    (take),
    .raddr (wr_col),
    .rdata (centre_rdata),
    .we    (take),
    .waddr (wr_col),
    .wdata (wr_val)
  );

  lsf_line_ram u_above_ram (
    .clk   (clk),
    .re    (take),
    .raddr (ctl.col),
    .rdata (above_rdata),
    .we    (above_wr.en),
    .waddr (above_wr.addr),
    .wdata (above_wr.data)
  );

  lsf_stencil u_stencil (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .take              (take),
    .ctl               (ctl),
    .centre_rdata      (centre_rdata),
    .above_rdata       (above_rdata),
    .above_wr          (above_wr),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_laplacian     (out_laplacian),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// ===== rtl/lsf_checker.sv =====
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks of the Laplacian stencil filter, bound to the top level.
// ----------------------------------------------------------------------------
module lsf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic signed [lsf_pkg::LAP_W-1:0] out_laplacian,
  input logic                           out_last_of_frame
);
  import lsf_pkg::*;

  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register is free");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_laplacian) && $stable(out_last_of_frame)))
    else $error("stalled result item changed");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_laplacian >= -11'sd1020) && (out_laplacian <= 11'sd1020)))
    else $error("result outside the stencil range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

endmodule

bind laplacian_stencil_filter lsf_checker u_lsf_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the streaming 5-point Laplacian filter. Frames of
// many geometries are streamed with random idle gaps on the input side and
// random stalls on the result side. A behavioral copy of the filter predicts
// each result when its item is accepted, and every result is checked in
// order against it. Directed frames cover the reset geometry, the value
// extremes, width and height clamping, early drains, surplus pixels and
// restarts by register writes; random frames with noise follow.
// ----------------------------------------------------------------------------
module tb;
  import lsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned IDLE_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS = 120;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [LAP_W-1:0] lap;
    logic                    last;
  } lap_result_t;

  logic                         clk;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         in_op = OP_PIXEL;
  logic [PIX_W-1:0]             in_pixel = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [LAP_W-1:0]      out_laplacian;
  logic                         out_last_of_frame;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  lap_result_t       pending[$];
  logic [FW_W-1:0]   width_reg;
  logic [FH_W-1:0]   height_reg;
  logic [PIX_W-1:0]  above_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  centre_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  win [3];
  int unsigned       in_col, in_row, out_col, out_row, lead_cnt;
  int unsigned       frames_done = 0;
  int unsigned       stream_items = 0;
  int unsigned       error_cnt = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       stall_hold = 0;
  int                in_idle_pct = 0;
  int                stall_pct = 0;

  laplacian_stencil_filter i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_laplacian    (out_laplacian),
    .out_last_of_frame(out_last_of_frame),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned width_in_use();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int unsigned height_in_use();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  function automatic void restart_stream();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    lead_cnt = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic void filter_reset();
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    foreach (above_mem[i]) above_mem[i] = '0;
    foreach (centre_mem[i]) centre_mem[i] = '0;
    restart_stream();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else if (idx == CFG_FRAME_HEIGHT) height_reg = val[FH_W-1:0];
    restart_stream();
  endfunction

  function automatic void stencil_step(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned      w, h, cq, c, r;
    logic [PIX_W-1:0] val, delayed, below, above;
    int               n_up, n_down, n_left, n_right, lap;
    bit               all_in, last;
    lap_result_t      res;
    w = width_in_use();
    h = height_in_use();
    all_in = (in_row >= h);
    if (op == OP_DRAIN && !all_in) return;
    stream_items++;
    val = (all_in || op == OP_DRAIN) ? '0 : pix;
    cq = in_col % w;
    c = out_col % w;
    r = out_row;
    delayed = centre_mem[cq];
    below = centre_mem[c];
    above = above_mem[c];
    win[0] = win[1];
    win[1] = win[2];
    win[2] = delayed;
    centre_mem[cq] = val;
    in_col = cq + 1;
    if (in_col >= w) begin
      in_col = 0;
      if (!all_in) in_row++;
    end
    if (lead_cnt <= w) begin
      lead_cnt++;
      return;
    end
    above_mem[c] = win[1];
    n_left = (c == 0) ? 0 : int'(win[0]);
    n_right = (c + 1 >= w) ? 0 : int'(win[2]);
    n_up = (r == 0) ? 0 : int'(above);
    n_down = (r + 1 >= h) ? 0 : int'(below);
    lap = n_up + n_down + n_left + n_right - 4 * int'(win[1]);
    last = (r + 1 >= h) && (c + 1 >= w);
    res.lap = lap[LAP_W-1:0];
    res.last = last;
    pending.insert(pending.size(), res);
    if (last) begin
      restart_stream();
      frames_done++;
    end else begin
      out_col = c + 1;
      if (out_col >= w) begin
        out_col = 0;
        out_row = r + 1;
      end
    end
  endfunction

  function automatic int unsigned pick_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int pick_pct();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) return 0;
    if (roll < 70) return 15;
    return 45;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 2) return '0;
    if (roll < 4) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic void report_error(input string msg);
    error_cnt++;
    if (error_cnt <= 10) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_hold <= pick_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_result
    lap_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report_error($sformatf("unexpected result laplacian %0d last_of_frame %0b",
                               out_laplacian, out_last_of_frame));
      end else begin
        want = pending[0];
        pending.delete(0);
        if (out_laplacian !== want.lap || out_last_of_frame !== want.last) begin
          report_error($sformatf("laplacian exp %0d got %0d, last_of_frame exp %0b got %0b",
                                 want.lap, out_laplacian, want.last, out_last_of_frame));
        end
      end
    end
  end

  task automatic push_item(input logic op, input logic [PIX_W-1:0] pix);
    int unsigned gap;
    gap = ($urandom_range(99) < in_idle_pct) ? pick_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_pixel <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stencil_step(op, pix);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic stream_frame(input int unsigned npix, input int noise_pct);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(99) < noise_pct) push_item(OP_DRAIN, PIX_W'($urandom));
      push_item(OP_PIXEL, pick_pixel());
    end
  endtask

  task automatic close_frame(input int noise_pct);
    int unsigned closed_at;
    closed_at = frames_done;
    while (frames_done == closed_at) begin
      if ($urandom_range(99) < noise_pct) push_item(OP_PIXEL, pick_pixel());
      else push_item(OP_DRAIN, PIX_W'($urandom));
    end
  endtask

  task automatic send_pattern(input logic [9*PIX_W-1:0] pat);
    for (int i = 0; i < 9; i++) push_item(OP_PIXEL, pat[9*PIX_W-1-PIX_W*i -: PIX_W]);
  endtask

  task automatic test_reset_geometry();
    in_idle_pct = 15;
    stall_pct = 15;
    stream_frame(MAX_WIDTH, 0);
    repeat (3) push_item(OP_DRAIN, PIX_W'($urandom));
  endtask

  task automatic test_extreme_values();
    write_reg(CFG_FRAME_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    push_item(OP_DRAIN, '1);
    send_pattern({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0});
    close_frame(0);
    push_item(OP_DRAIN, '0);
    send_pattern({8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255});
    close_frame(50);
  endtask

  task automatic test_width_limits();
    write_reg(CFG_FRAME_WIDTH, 16'h0000);
    write_reg(CFG_FRAME_HEIGHT, 16'd4);
    stream_frame(4, 0);
    close_frame(0);
    write_reg(CFG_FRAME_WIDTH, 16'h07FF);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    stream_frame(64, 5);
    write_reg(CFG_FRAME_WIDTH, 16'hF801);
    stream_frame(1, 0);
    close_frame(0);
  endtask

  task automatic test_height_limits();
    write_reg(CFG_FRAME_WIDTH, 16'd5);
    write_reg(CFG_FRAME_HEIGHT, 16'h0000);
    stream_frame(5, 0);
    close_frame(0);
    write_reg(CFG_FRAME_WIDTH, 16'd2);
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    stream_frame(40, 10);
  endtask

  task automatic test_restart();
    write_reg(CFG_UNUSED_2, CFG_DATA_W'($urandom));
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    stream_frame(4, 0);
    write_reg(CFG_UNUSED_3, CFG_DATA_W'($urandom));
    stream_frame(6, 0);
    close_frame(0);
  endtask

  task automatic test_random_frames();
    int unsigned base, npix, wv, hv, roll;
    int          noise;
    bit          restart_due;
    restart_due = 1'b1;
    base = stream_items;
    while (stream_items - base < RANDOM_ITEMS) begin
      in_idle_pct = pick_pct();
      stall_pct = pick_pct();
      noise = ($urandom_range(1) == 0) ? 0 : $urandom_range(15, 1);
      if (restart_due || $urandom_range(1) == 0) begin
        if (restart_due && $urandom_range(2) == 0) begin
          write_reg(CFG_UNUSED_3, CFG_DATA_W'($urandom));
        end
        roll = $urandom_range(99);
        if (roll < 3) wv = 0;
        else if (roll < 80) wv = $urandom_range(8, 1);
        else if (roll < 97) wv = $urandom_range(64, 9);
        else wv = $urandom_range(200, 65);
        roll = $urandom_range(99);
        if (wv > 8) hv = $urandom_range(2, 1);
        else if (roll < 3) hv = 0;
        else if (roll < 75) hv = $urandom_range(6, 1);
        else hv = $urandom_range(20, 7);
        write_reg(CFG_FRAME_WIDTH, {5'($urandom_range(31)), 11'(wv)});
        write_reg(CFG_FRAME_HEIGHT, 16'(hv));
        restart_due = 1'b0;
      end
      npix = width_in_use() * height_in_use();
      if ($urandom_range(9) == 0) begin
        stream_frame($urandom_range(npix), noise);
        restart_due = 1'b1;
      end else begin
        stream_frame(npix, noise);
        close_frame(noise);
        if ($urandom_range(3) == 0) push_item(OP_DRAIN, PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    filter_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_geometry();
    test_extreme_values();
    test_width_limits();
    test_height_limits();
    test_restart();
    test_random_frames();
    wait_idle();
    if (error_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
